// ===== rtl/clpr_pkg.sv =====
// ============================================================================
// clpr_pkg
// Shared widths, register indexes and controller/datapath interface types
// for the contour line pixel renderer.
// ============================================================================
package clpr_pkg;

    // grid geometry
    localparam int MAX_ROWS    = 1024;
    localparam int MAX_COLUMNS = 1024;
    localparam int MAX_LEVELS  = 16;
    localparam int MIN_SIZE    = 3;
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int LVL_IDX_W   = $clog2(MAX_LEVELS);

    // register field widths
    localparam int SIZE_W     = 11;
    localparam int Z_W        = 24;
    localparam int STEP_W     = 23;
    localparam int CNT_W      = 5;
    localparam int LW_W       = 4;
    localparam int COLOR_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // datapath widths
    localparam int G2_W    = 2 * Z_W + 2;
    localparam int G2_LO_W = G2_W / 2;
    localparam int G2_HI_W = G2_W - G2_LO_W;
    localparam int LEVEL_W = 29;
    localparam int DZ_W    = 29;
    localparam int DZ2_W   = 2 * DZ_W;
    localparam int LHS_W   = DZ2_W + 4;
    localparam int H_W     = LW_W + 1;
    localparam int HSQ_W   = 9;
    localparam int RHS_W   = HSQ_W + G2_W;
    localparam int THR_W   = DZ2_W + 20;
    localparam int L_W     = 14;
    localparam int LM_W    = 12;
    localparam int L2_W    = 2 * LM_W;
    localparam int PP_W    = L2_W + G2_LO_W;
    localparam int FADE_W  = 8;

    localparam logic [FADE_W-1:0] FADE_MIN = 8'd1;
    localparam logic [FADE_W-1:0] FADE_MAX = 8'd255;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_BASE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_STEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_COUNT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_COLOR   = 3'd6;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic rd_a;
        logic rd_b;
        logic wr;
        logic grad;
        logic g2;
        logic scale;
        logic lvl;
        logic sq;
        logic step_next;
        logic set_full;
        logic set_none;
        logic fade_init;
        logic f_mid;
        logic f_lo;
        logic f_hi;
        logic f_cmp;
        logic set_fade;
        logic out_load;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic interior;
        logic g2_zero;
        logic cnt_zero;
        logic full_hit;
        logic part_hit;
        logic last_level;
        logic fade_done;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== rtl/clpr_ram.sv =====
// ============================================================================
// clpr_ram
// Generic single write port, single read port RAM with registered read data.
// ============================================================================
module clpr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/clpr_datapath.sv =====
// ============================================================================
// clpr_datapath
// Register file, column memories, gradient and level arithmetic, alpha fade
// search and the output register of the contour line pixel renderer.
// ============================================================================
module clpr_datapath import clpr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic signed [Z_W-1:0] i_z_sample,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [COL_W-1:0]      o_pixel_x,
    output logic [ROW_W-1:0]      o_pixel_y,
    output logic [COLOR_W-1:0]    o_pixel_color,
    output logic                  o_pixel_drawn
);

    // configuration registers
    logic [SIZE_W-1:0]         r_grid_rows;
    logic [SIZE_W-1:0]         r_grid_cols;
    logic signed [Z_W-1:0]     r_level_base;
    logic [STEP_W-1:0]         r_level_step;
    logic [CNT_W-1:0]          r_level_count;
    logic [LW_W-1:0]           r_line_width;
    logic [COLOR_W-1:0]        r_line_color;

    // position and item registers
    logic [ROW_W-1:0]          r_row_pos;
    logic [COL_W-1:0]          r_col_pos;
    logic [ROW_W-1:0]          r_r;
    logic [COL_W-1:0]          r_c;
    logic signed [Z_W-1:0]     r_z;
    logic signed [Z_W-1:0]     r_centre;
    logic signed [Z_W-1:0]     r_old_r;
    logic signed [Z_W-1:0]     r_upper;
    logic signed [Z_W-1:0]     r_lower;

    // arithmetic registers
    logic [G2_W-1:0]           r_dx2;
    logic [G2_W-1:0]           r_dy2;
    logic [G2_W-1:0]           r_g2;
    logic [RHS_W-1:0]          r_full_rhs;
    logic [RHS_W-1:0]          r_part_rhs;
    logic signed [LEVEL_W-1:0] r_level;
    logic [CNT_W-1:0]          r_k;
    logic [DZ_W-1:0]           r_dz;
    logic [DZ2_W-1:0]          r_dz2;
    logic [THR_W-1:0]          r_thr;
    logic [FADE_W-1:0]         r_lo;
    logic [FADE_W-1:0]         r_hi;
    logic [FADE_W-1:0]         r_mid;
    logic                      r_lneg;
    logic [L2_W-1:0]           r_l2;
    logic [PP_W-1:0]           r_plo;
    logic [PP_W-1:0]           r_phi;
    logic [COLOR_W-1:0]        r_color;
    logic                      r_drawn;

    // output register
    logic                      r_out_valid;
    logic [COL_W-1:0]          r_out_x;
    logic [ROW_W-1:0]          r_out_y;
    logic [COLOR_W-1:0]        r_out_color;
    logic                      r_out_drawn;

    // combinational values
    logic [SIZE_W-1:0]         w_rows;
    logic [SIZE_W-1:0]         w_cols;
    logic [SIZE_W-1:0]         w_r_inc;
    logic [SIZE_W-1:0]         w_c_inc;
    logic [CNT_W-1:0]          w_count;
    logic [CNT_W-1:0]          w_cnt_m1;
    logic [LVL_IDX_W+STEP_W-1:0] w_top_off;
    logic signed [LEVEL_W-1:0] w_top;
    logic [H_W-1:0]            w_h;
    logic [H_W-1:0]            w_hm2;
    logic [HSQ_W-1:0]          w_h_sq;
    logic [HSQ_W-1:0]          w_hm2_sq;
    logic signed [Z_W:0]       w_dx;
    logic signed [Z_W:0]       w_dy;
    logic signed [G2_W-1:0]    w_dx_sq;
    logic signed [G2_W-1:0]    w_dy_sq;
    logic signed [LEVEL_W:0]   w_d;
    logic [LHS_W-1:0]          w_lhs;
    logic [FADE_W:0]           w_sum;
    logic [FADE_W-1:0]         w_mid;
    logic signed [L_W-1:0]     w_hm2s;
    logic signed [L_W-1:0]     w_l;
    logic [LM_W-1:0]           w_lm;
    logic [THR_W-1:0]          w_p;
    logic                      w_pass;
    logic [ROW_W-1:0]          w_prev_raddr;
    logic [ROW_W-1:0]          w_old_raddr;
    logic [Z_W-1:0]            w_prev_rdata;
    logic [Z_W-1:0]            w_old_rdata;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows   <= SIZE_W'(1024);
            r_grid_cols   <= SIZE_W'(1024);
            r_level_base  <= '0;
            r_level_step  <= STEP_W'(256);
            r_level_count <= CNT_W'(2);
            r_line_width  <= LW_W'(1);
            r_line_color  <= 32'hFF0000FF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GRID_ROWS:    r_grid_rows   <= i_cfg_data[SIZE_W-1:0];
                CFG_GRID_COLUMNS: r_grid_cols   <= i_cfg_data[SIZE_W-1:0];
                CFG_LEVEL_BASE:   r_level_base  <= signed'(i_cfg_data[Z_W-1:0]);
                CFG_LEVEL_STEP:   r_level_step  <= i_cfg_data[STEP_W-1:0];
                CFG_LEVEL_COUNT:  r_level_count <= i_cfg_data[CNT_W-1:0];
                CFG_LINE_WIDTH:   r_line_width  <= i_cfg_data[LW_W-1:0];
                CFG_LINE_COLOR:   r_line_color  <= i_cfg_data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    // clamped geometry and level setup
    assign w_rows = (r_grid_rows < SIZE_W'(MIN_SIZE)) ? SIZE_W'(MIN_SIZE) :
                    (r_grid_rows > SIZE_W'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS) : r_grid_rows;
    assign w_cols = (r_grid_cols < SIZE_W'(MIN_SIZE)) ? SIZE_W'(MIN_SIZE) :
                    (r_grid_cols > SIZE_W'(MAX_COLUMNS)) ? SIZE_W'(MAX_COLUMNS) : r_grid_cols;
    assign w_r_inc  = SIZE_W'(r_r) + SIZE_W'(1);
    assign w_c_inc  = SIZE_W'(r_c) + SIZE_W'(1);
    assign w_count  = (r_level_count > CNT_W'(MAX_LEVELS)) ? CNT_W'(MAX_LEVELS) : r_level_count;
    assign w_cnt_m1 = w_count - CNT_W'(1);
    assign w_top_off = w_cnt_m1[LVL_IDX_W-1:0] * r_level_step;
    assign w_top    = LEVEL_W'(r_level_base) + signed'(LEVEL_W'(w_top_off));
    assign w_h      = H_W'(r_line_width) + H_W'(1);
    assign w_hm2    = w_h - H_W'(2);
    assign w_h_sq   = HSQ_W'(w_h) * HSQ_W'(w_h);
    assign w_hm2_sq = HSQ_W'(w_hm2) * HSQ_W'(w_hm2);

    // column memories: addresses r, then r+1 (previous) and r-1 (older)
    assign w_prev_raddr = i_cmd.rd_a ? r_r : r_r + ROW_W'(1);
    assign w_old_raddr  = i_cmd.rd_a ? r_r : r_r - ROW_W'(1);

    clpr_ram #(.WIDTH(Z_W), .DEPTH(MAX_ROWS)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr),
        .i_waddr (r_r),
        .i_wdata (r_z),
        .i_re    (i_cmd.rd_a | i_cmd.rd_b),
        .i_raddr (w_prev_raddr),
        .o_rdata (w_prev_rdata)
    );

    clpr_ram #(.WIDTH(Z_W), .DEPTH(MAX_ROWS)) u_old_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr),
        .i_waddr (r_r),
        .i_wdata (r_centre),
        .i_re    (i_cmd.rd_a | i_cmd.rd_b),
        .i_raddr (w_old_raddr),
        .o_rdata (w_old_rdata)
    );

    // gradient terms
    assign w_dx    = (Z_W+1)'(r_z) - (Z_W+1)'(r_old_r);
    assign w_dy    = (Z_W+1)'(r_upper) - (Z_W+1)'(r_lower);
    assign w_dx_sq = w_dx * w_dx;
    assign w_dy_sq = w_dy * w_dy;

    // level distance and line tests
    assign w_d   = (LEVEL_W+1)'(r_centre) - (LEVEL_W+1)'(r_level);
    assign w_lhs = {r_dz2, 4'b0000};

    // fade search step
    assign w_sum  = (FADE_W+1)'(r_lo) + (FADE_W+1)'(r_hi);
    assign w_mid  = w_sum[FADE_W:1];
    assign w_hm2s = signed'(L_W'(w_h)) - signed'(L_W'(2));
    assign w_l    = signed'(L_W'({w_mid, 1'b0})) + (w_hm2s <<< 8) - w_hm2s;
    assign w_lm   = w_l[LM_W-1:0];
    assign w_p    = (THR_W'(r_phi) << G2_LO_W) + THR_W'(r_plo);
    assign w_pass = !r_lneg && (w_p >= r_thr);

    // control-side registers: positions, level counter, fade bounds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_pos <= '0;
            r_col_pos <= '0;
            r_k       <= '0;
            r_lo      <= FADE_MIN;
            r_hi      <= FADE_MAX;
        end else begin
            if (i_cmd.wr) begin
                if (w_r_inc >= w_rows) begin
                    r_row_pos <= '0;
                    r_col_pos <= (w_c_inc >= w_cols) ? '0 : w_c_inc[COL_W-1:0];
                end else begin
                    r_row_pos <= w_r_inc[ROW_W-1:0];
                end
            end
            if (i_cmd.g2) begin
                r_k <= w_count;
            end else if (i_cmd.step_next) begin
                r_k <= r_k - CNT_W'(1);
            end
            if (i_cmd.fade_init) begin
                r_lo <= FADE_MIN;
                r_hi <= FADE_MAX;
            end else if (i_cmd.f_cmp) begin
                if (w_pass) begin
                    r_hi <= r_mid;
                end else begin
                    r_lo <= r_mid + FADE_W'(1);
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_z <= i_z_sample;
            r_r <= (SIZE_W'(r_row_pos) >= w_rows) ? '0 : r_row_pos;
            r_c <= (SIZE_W'(r_col_pos) >= w_cols) ? '0 : r_col_pos;
        end
        if (i_cmd.rd_b) begin
            r_centre <= signed'(w_prev_rdata);
            r_old_r  <= signed'(w_old_rdata);
        end
        if (i_cmd.wr) begin
            r_upper <= signed'(w_prev_rdata);
            r_lower <= signed'(w_old_rdata);
        end
        if (i_cmd.grad) begin
            r_dx2 <= unsigned'(w_dx_sq);
            r_dy2 <= unsigned'(w_dy_sq);
        end
        if (i_cmd.g2) begin
            r_g2    <= r_dx2 + r_dy2;
            r_level <= w_top;
        end else if (i_cmd.step_next) begin
            r_level <= r_level - signed'(LEVEL_W'(r_level_step));
        end
        if (i_cmd.scale) begin
            r_full_rhs <= RHS_W'(w_hm2_sq) * RHS_W'(r_g2);
            r_part_rhs <= RHS_W'(w_h_sq) * RHS_W'(r_g2);
        end
        if (i_cmd.lvl) begin
            r_dz <= w_d[LEVEL_W] ? DZ_W'(-w_d) : DZ_W'(w_d);
        end
        if (i_cmd.sq) begin
            r_dz2 <= DZ2_W'(r_dz) * DZ2_W'(r_dz);
        end
        // 1040400 * dz^2 as shifts: 2^20 - 2^13 + 2^4
        if (i_cmd.fade_init) begin
            r_thr <= (THR_W'(r_dz2) << 20) - (THR_W'(r_dz2) << 13) + (THR_W'(r_dz2) << 4);
        end
        if (i_cmd.f_mid) begin
            r_mid  <= w_mid;
            r_lneg <= w_l[L_W-1];
            r_l2   <= w_lm * w_lm;
        end
        if (i_cmd.f_lo) begin
            r_plo <= PP_W'(r_l2) * PP_W'(r_g2[G2_LO_W-1:0]);
        end
        if (i_cmd.f_hi) begin
            r_phi <= PP_W'(r_l2) * PP_W'(r_g2[G2_W-1:G2_LO_W]);
        end
        if (i_cmd.set_full) begin
            r_color <= r_line_color;
            r_drawn <= 1'b1;
        end else if (i_cmd.set_fade) begin
            r_color <= r_line_color - COLOR_W'(r_lo);
            r_drawn <= 1'b1;
        end else if (i_cmd.set_none) begin
            r_color <= '0;
            r_drawn <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out_x     <= r_c - COL_W'(1);
            r_out_y     <= ROW_W'(w_rows - SIZE_W'(1) - SIZE_W'(r_r));
            r_out_color <= r_color;
            r_out_drawn <= r_drawn;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // status
    assign o_sts.interior   = (r_c >= COL_W'(2)) && (r_r >= ROW_W'(1)) && (w_r_inc < w_rows);
    assign o_sts.g2_zero    = (r_g2 == '0);
    assign o_sts.cnt_zero   = (w_count == '0);
    assign o_sts.full_hit   = (r_line_width != '0) && (w_lhs <= LHS_W'(r_full_rhs));
    assign o_sts.part_hit   = (w_lhs <= LHS_W'(r_part_rhs));
    assign o_sts.last_level = (r_k == CNT_W'(1));
    assign o_sts.fade_done  = (r_lo == r_hi);
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid   = r_out_valid;
    assign o_pixel_x     = r_out_x;
    assign o_pixel_y     = r_out_y;
    assign o_pixel_color = r_out_color;
    assign o_pixel_drawn = r_out_drawn;

    // a result never overwrites one still waiting
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !(r_out_valid && i_out_stall))
        else $error("output register overwritten while stalled");

    // fade search bounds stay ordered
    a_fade_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lo <= r_hi)
        else $error("fade search bounds crossed");

    // fade amount is never zero when applied
    a_fade_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.set_fade |-> (r_lo != '0) && (r_lo == r_hi))
        else $error("fade amount applied before search finished");

endmodule

// ===== rtl/clpr_ctrl.sv =====
// ============================================================================
// clpr_ctrl
// Sequencer of the contour line pixel renderer: memory access, gradient,
// level scan, fade search and result handoff.
// ============================================================================
module clpr_ctrl import clpr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD0   = 4'd1;
    localparam logic [3:0] S_RD1   = 4'd2;
    localparam logic [3:0] S_RD2   = 4'd3;
    localparam logic [3:0] S_GRAD  = 4'd4;
    localparam logic [3:0] S_SUM   = 4'd5;
    localparam logic [3:0] S_SCALE = 4'd6;
    localparam logic [3:0] S_LVL   = 4'd7;
    localparam logic [3:0] S_SQ    = 4'd8;
    localparam logic [3:0] S_TST   = 4'd9;
    localparam logic [3:0] S_FMID  = 4'd10;
    localparam logic [3:0] S_FLO   = 4'd11;
    localparam logic [3:0] S_FHI   = 4'd12;
    localparam logic [3:0] S_FCMP  = 4'd13;
    localparam logic [3:0] S_OUT   = 4'd14;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_RD0;
                end
            end
            S_RD0: begin
                o_cmd.rd_a = 1'b1;
                n_state    = S_RD1;
            end
            S_RD1: begin
                o_cmd.rd_b = 1'b1;
                n_state    = S_RD2;
            end
            S_RD2: begin
                o_cmd.wr = 1'b1;
                n_state  = i_sts.interior ? S_GRAD : S_IDLE;
            end
            S_GRAD: begin
                o_cmd.grad = 1'b1;
                n_state    = S_SUM;
            end
            S_SUM: begin
                o_cmd.g2 = 1'b1;
                n_state  = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                if (i_sts.g2_zero || i_sts.cnt_zero) begin
                    o_cmd.set_none = 1'b1;
                    n_state        = S_OUT;
                end else begin
                    n_state = S_LVL;
                end
            end
            S_LVL: begin
                o_cmd.lvl = 1'b1;
                n_state   = S_SQ;
            end
            S_SQ: begin
                o_cmd.sq = 1'b1;
                n_state  = S_TST;
            end
            // levels scanned from the top: the first hit decides
            S_TST: begin
                if (i_sts.full_hit) begin
                    o_cmd.set_full = 1'b1;
                    n_state        = S_OUT;
                end else if (i_sts.part_hit) begin
                    o_cmd.fade_init = 1'b1;
                    n_state         = S_FMID;
                end else if (i_sts.last_level) begin
                    o_cmd.set_none = 1'b1;
                    n_state        = S_OUT;
                end else begin
                    o_cmd.step_next = 1'b1;
                    n_state         = S_LVL;
                end
            end
            S_FMID: begin
                if (i_sts.fade_done) begin
                    o_cmd.set_fade = 1'b1;
                    n_state        = S_OUT;
                end else begin
                    o_cmd.f_mid = 1'b1;
                    n_state     = S_FLO;
                end
            end
            S_FLO: begin
                o_cmd.f_lo = 1'b1;
                n_state    = S_FHI;
            end
            S_FHI: begin
                o_cmd.f_hi = 1'b1;
                n_state    = S_FCMP;
            end
            S_FCMP: begin
                o_cmd.f_cmp = 1'b1;
                n_state     = S_FMID;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    // a transfer always starts the memory read sequence
    a_accept_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_RD0))
        else $error("accepted sample did not start memory read");

endmodule

// ===== rtl/contour_line_pixel_renderer.sv =====
// ============================================================================
// contour_line_pixel_renderer
// Streams a column-major height grid, keeps the two latest columns and emits
// one antialiased contour line pixel for every interior grid point.
// ============================================================================
//
//  channel   direction  handshake                  payload
//  -------   ---------  -------------------------  ---------------------------
//  input     in         i_in_valid / o_in_stall    i_z_sample
//  output    out        o_out_valid / i_out_stall  o_pixel_x/y/color/drawn
//  config    in         i_cfg_we                   i_cfg_idx, i_cfg_data
//
//  A sample with no result ends after the column memory access; an interior
//  one also scans the contour levels (top level down, stopping at the first
//  hit) and on a partial hit runs the 8-step alpha fade search. With one
//  read port per column memory, the four neighbor reads are split over
//  states RD0 and RD1. Reset is synchronous, active low, and needs no
//  clearing pass. A stalled result is held in the output register; a new
//  sample is taken only once the previous result has moved into it.
//
module contour_line_pixel_renderer import clpr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic signed [Z_W-1:0] i_z_sample,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [COL_W-1:0]      o_pixel_x,
    output logic [ROW_W-1:0]      o_pixel_y,
    output logic [COLOR_W-1:0]    o_pixel_color,
    output logic                  o_pixel_drawn
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // sequencer
    clpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // arithmetic, memories and output register
    clpr_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_z_sample    (i_z_sample),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_color (o_pixel_color),
        .o_pixel_drawn (o_pixel_drawn)
    );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contour line pixel renderer testbench
// Streams whole height frames through the renderer under several register
// settings, predicts every interior pixel in an internal golden model and
// compares each output transfer field by field, with random gaps on both sides.
// ----------------------------------------------------------------------------
module testbench;
    import clpr_pkg::*;

    typedef struct {
        logic [COL_W-1:0]   x;
        logic [ROW_W-1:0]   y;
        logic [COLOR_W-1:0] color;
        logic               drawn;
    } t_pixel;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 120;

    // stimulus styles for a frame
    typedef enum int {HT_RANDOM, HT_FLAT, HT_RAMP, HT_NEAR} t_height_style;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic signed [Z_W-1:0] i_z_sample = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [COL_W-1:0]      o_pixel_x;
    logic [ROW_W-1:0]      o_pixel_y;
    logic [COLOR_W-1:0]    o_pixel_color;
    logic                  o_pixel_drawn;

    contour_line_pixel_renderer DUT (.*);

    always #2 i_clk = ~i_clk;

    // golden copy of registers and column store
    int unsigned    rows_reg, cols_reg, base_reg, step_reg, count_reg, width_reg;
    logic [31:0]    color_reg;
    int             prev_col [MAX_ROWS];
    int             old_col  [MAX_ROWS];
    int unsigned    row_pos, col_pos;

    logic [Z_W-1:0] heights_pending [$];
    t_pixel         pixels_due [$];
    int             fail_count = 0;
    bit             steady_send = 0;
    bit             steady_recv = 0;
    int             quiet_cycles = 0;

    function automatic int unsigned fit_size(int unsigned v, int unsigned maxv);
        if (v < 3) return 3;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic longint sext24(int unsigned v);
        return longint'({{40{v[23]}}, v[23:0]});
    endfunction

    // least alpha reduction m with (2m + 255(h-2))^2 * g2 >= 1020^2 * dz^2
    function automatic logic [7:0] alpha_cut(longint unsigned dz, longint unsigned g2,
                                             int h);
        logic [127:0] lhs, rhs;
        longint       l;
        rhs = 128'(1040400) * 128'(dz) * 128'(dz);
        for (int m = 1; m < 255; m++) begin
            l = 2 * m + 255 * (h - 2);
            if (l < 0) continue;
            lhs = 128'(l) * 128'(l) * 128'(g2);
            if (lhs >= rhs) return 8'(m);
        end
        return 8'd255;
    endfunction

    // advance the golden model by one height sample
    task automatic render_pixel(logic [Z_W-1:0] zin);
        int unsigned rows, cols, r, c, h, cnt;
        longint z, centre, dx, dy, lvl, d, base;
        longint unsigned g2, dz, dzc, lhs;
        t_pixel p;
        rows = fit_size(rows_reg, MAX_ROWS);
        cols = fit_size(cols_reg, MAX_COLUMNS);
        z = sext24(zin);
        if (row_pos >= rows) row_pos = 0;
        if (col_pos >= cols) col_pos = 0;
        r = row_pos;
        c = col_pos;
        if (c >= 2 && r >= 1 && r + 1 < rows) begin
            centre = prev_col[r];
            dx = z - old_col[r];
            dy = longint'(prev_col[r+1]) - old_col[r-1];
            g2 = dx * dx + dy * dy;
            h = width_reg + 1;
            cnt = count_reg > MAX_LEVELS ? MAX_LEVELS : count_reg;
            base = sext24(base_reg);
            p.color = '0;
            p.drawn = 1'b0;
            if (g2 != 0) begin
                for (int k = 0; k < cnt; k++) begin
                    lvl = base + longint'(k) * step_reg;
                    d = centre - lvl;
                    dz = d < 0 ? -d : d;
                    dzc = dz > (64'd1 << 29) ? (64'd1 << 29) : dz;
                    lhs = 16 * dzc * dzc;
                    if (h >= 2 && lhs <= longint'(h - 2) * (h - 2) * g2) begin
                        p.color = color_reg;
                        p.drawn = 1'b1;
                    end else if (lhs <= longint'(h) * h * g2) begin
                        p.color = color_reg - alpha_cut(dz, g2, h);
                        p.drawn = 1'b1;
                    end
                end
            end
            p.x = COL_W'(c - 1);
            p.y = ROW_W'(rows - 1 - r);
            pixels_due.push_back(p);
        end
        old_col[r] = prev_col[r];
        prev_col[r] = int'(z);
        if (r + 1 >= rows) begin
            row_pos = 0;
            col_pos = (c + 1 >= cols) ? 0 : c + 1;
        end else begin
            row_pos = r + 1;
        end
    endtask

    function automatic int pick_gap(bit steady);
        int u;
        if (steady) return 0;
        u = $urandom_range(0, 99);
        if (u < 55) return 0;
        if (u < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        fail_count++;
    endtask

    // input driver: transfers heights from the pending queue
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) render_pixel(i_z_sample);
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (heights_pending.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_z_sample <= heights_pending.pop_front();
                    send_gap = pick_gap(steady_send);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor with random stall
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pixels_due.size() == 0) begin
                    report_mismatch("unexpected pixel transfer x/y", {o_pixel_x, o_pixel_y}, 0);
                end else begin
                    want = pixels_due.pop_front();
                    if (o_pixel_x !== want.x) report_mismatch("pixel_x", o_pixel_x, want.x);
                    if (o_pixel_y !== want.y) report_mismatch("pixel_y", o_pixel_y, want.y);
                    if (o_pixel_color !== want.color)
                        report_mismatch("pixel_color", o_pixel_color, want.color);
                    if (o_pixel_drawn !== want.drawn)
                        report_mismatch("pixel_drawn", o_pixel_drawn, want.drawn);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                stall_left = pick_gap(steady_recv);
                i_out_stall <= (stall_left > 0);
            end
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired, %0d pixels outstanding", pixels_due.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_GRID_ROWS:    rows_reg  = data & 32'h7FF;
            CFG_GRID_COLUMNS: cols_reg  = data & 32'h7FF;
            CFG_LEVEL_BASE:   base_reg  = data & 32'hFFFFFF;
            CFG_LEVEL_STEP:   step_reg  = data & 32'h7FFFFF;
            CFG_LEVEL_COUNT:  count_reg = data & 32'h1F;
            CFG_LINE_WIDTH:   width_reg = data & 32'hF;
            CFG_LINE_COLOR:   color_reg = data;
            default: ;
        endcase
    endtask

    task automatic cfg_close();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // wait for all pixels, then let the block settle
    task automatic drain();
        while (heights_pending.size() > 0 || i_in_valid || pixels_due.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // queue one whole frame of heights in the chosen style
    task automatic queue_frame(t_height_style style);
        int unsigned rows, cols;
        longint org, sr, sc, v;
        rows = fit_size(rows_reg, MAX_ROWS);
        cols = fit_size(cols_reg, MAX_COLUMNS);
        org = sext24(base_reg);
        sr = longint'($urandom_range(0, 600)) - 300;
        sc = longint'($urandom_range(0, 600)) - 300;
        for (int c = 0; c < cols; c++) begin
            for (int r = 0; r < rows; r++) begin
                case (style)
                    HT_RANDOM: v = $urandom();
                    HT_FLAT:   v = org;
                    HT_RAMP:   v = org + r * sr + c * sc + $urandom_range(0, 3);
                    default:   v = org + longint'($urandom_range(0, 3)) * step_reg
                                   + longint'($urandom_range(0, 255)) - 128;
                endcase
                heights_pending.push_back(Z_W'(v));
            end
        end
    endtask

    task automatic retune(bit big);
        int u;
        u = $urandom_range(0, 9);
        if (!big) begin
            cfg_write(CFG_GRID_ROWS, u == 0 ? $urandom_range(0, 2) : $urandom_range(3, 9));
            cfg_write(CFG_GRID_COLUMNS,
                      u == 1 ? $urandom_range(0, 2) : $urandom_range(3, 9));
        end
        u = $urandom_range(0, 9);
        cfg_write(CFG_LEVEL_BASE, u == 0 ? 32'h800000 : u == 1 ? 32'h7FFFFF :
                  u < 5 ? $urandom() : $urandom_range(0, 8192) - 4096);
        u = $urandom_range(0, 9);
        cfg_write(CFG_LEVEL_STEP, u == 0 ? 1 : u == 1 ? 32'h7FFFFF :
                  u == 2 ? $urandom() : $urandom_range(1, 2048));
        u = $urandom_range(0, 9);
        cfg_write(CFG_LEVEL_COUNT, u == 0 ? $urandom_range(0, 31) :
                  u == 1 ? 16 : $urandom_range(2, 16));
        cfg_write(CFG_LINE_WIDTH, $urandom_range(0, 15));
        u = $urandom_range(0, 9);
        cfg_write(CFG_LINE_COLOR, u == 0 ? 32'h0 : u == 1 ? 32'hFFFFFFFF : $urandom());
        cfg_close();
    endtask

    int sent;
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        rows_reg = 1024; cols_reg = 1024; base_reg = 0; step_reg = 256;
        count_reg = 2; width_reg = 1; color_reg = 32'hFF0000FF;
        row_pos = 0; col_pos = 0;
        for (int i = 0; i < MAX_ROWS; i++) begin
            prev_col[i] = 0;
            old_col[i] = 0;
        end

        // directed: extreme heights, a ramp frame with zero line width, then a flat frame with zero gradient
        cfg_write(CFG_GRID_ROWS, 3);
        cfg_write(CFG_GRID_COLUMNS, 3);
        cfg_close();
        heights_pending = '{24'h800000, 24'h7FFFFF, 24'h000000,
                            24'h7FFFFF, 24'h000000, 24'h800000,
                            24'h000000, 24'h800000, 24'h7FFFFF};
        drain();
        cfg_write(CFG_LINE_WIDTH, 0);
        cfg_write(CFG_LINE_COLOR, 32'h12345600);
        cfg_close();
        queue_frame(HT_RAMP);
        drain();
        cfg_write(CFG_GRID_COLUMNS, 4);
        cfg_write(CFG_LEVEL_COUNT, 0);
        cfg_close();
        queue_frame(HT_FLAT);
        drain();

        // random frames of small size
        sent = 0;
        while (sent < 700) begin
            retune(0);
            steady_send = ($urandom_range(0, 4) == 0);
            steady_recv = ($urandom_range(0, 4) == 0);
            queue_frame(t_height_style'($urandom_range(0, 9) < 2 ? HT_RANDOM :
                        $urandom_range(0, 9) == 0 ? HT_FLAT :
                        $urandom_range(0, 1) ? HT_RAMP : HT_NEAR));
            sent += heights_pending.size();
            drain();
        end

        // a tall and a wide frame, one each
        steady_send = 0;
        steady_recv = 0;
        cfg_write(CFG_GRID_ROWS, 200);
        cfg_write(CFG_GRID_COLUMNS, 3);
        cfg_close();
        retune(1);
        queue_frame(HT_RAMP);
        drain();
        cfg_write(CFG_GRID_ROWS, 3);
        cfg_write(CFG_GRID_COLUMNS, 40);
        cfg_close();
        retune(1);
        queue_frame(HT_NEAR);
        drain();

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
